>>> sv/lncs_pkg.sv
// Shared types, codes, constants and lookup functions of the LCD nibble command sequencer.
package lncs_pkg;

    // Command opcodes.
    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_RAW    = 3'd1;
    localparam logic [2:0] OP_DATA   = 3'd2;
    localparam logic [2:0] OP_CURSOR = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;
    localparam logic [2:0] OP_HOME   = 3'd5;

    // Kinds of work handed from the front to the back.
    localparam logic [1:0] KIND_INIT  = 2'd0;
    localparam logic [1:0] KIND_SEND  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Extra waits added after the final write of a send.
    localparam logic [1:0] EXTRA_NONE  = 2'd0;
    localparam logic [1:0] EXTRA_DATA  = 2'd1;
    localparam logic [1:0] EXTRA_CLEAR = 2'd2;

    localparam logic [7:0] ENABLE_BIT    = 8'h04;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] MAX_LINE      = 8'd3;

    localparam logic [15:0] WAIT_POWER_UP_US = 16'd50000;
    localparam logic [19:0] STEP_US          = 20'd50;
    localparam logic [19:0] EXTRA_DATA_US    = 20'd50;
    localparam logic [19:0] EXTRA_CLEAR_US   = 20'd2000;

    // Initialisation runs over fifteen nibbles: five single high nibbles and five full bytes.
    localparam logic [3:0] INIT_LAST_NIBBLE = 4'd14;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] value;
        logic       rs_flag;
        logic       rw_flag;
        logic       both_nibbles;
    } lncs_cmd_t;

    typedef struct packed {
        logic [7:0]  expander_byte;
        logic [15:0] wait_before_us;
        logic [19:0] wait_after_us;
        logic        error;
        logic        last;
    } lncs_res_t;

    // Classified command as it waits in the queue.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       rs;
        logic       rw;
        logic       two;
        logic [1:0] extra;
    } lncs_desc_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } lncs_qstat_t;

    function automatic logic [3:0] init_nibble(input logic [3:0] idx);
        logic [3:0] nib;
        unique case (idx)
            4'd0:    nib = 4'h0;
            4'd1:    nib = 4'h3;
            4'd2:    nib = 4'h3;
            4'd3:    nib = 4'h3;
            4'd4:    nib = 4'h2;
            4'd5:    nib = 4'h2;
            4'd6:    nib = 4'h8;
            4'd7:    nib = 4'h2;
            4'd8:    nib = 4'h8;
            4'd9:    nib = 4'h0;
            4'd10:   nib = 4'hF;
            4'd11:   nib = 4'h0;
            4'd12:   nib = 4'h1;
            4'd13:   nib = 4'h0;
            4'd14:   nib = 4'h6;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

    function automatic logic [19:0] init_extra(input logic [3:0] idx);
        logic [19:0] us;
        unique case (idx)
            4'd0:    us = 20'd1000000;
            4'd1:    us = 20'd4500;
            4'd2:    us = 20'd4500;
            4'd3:    us = 20'd150;
            default: us = 20'd0;
        endcase
        return us;
    endfunction

    function automatic logic [7:0] line_addr(input logic [1:0] line);
        logic [7:0] addr;
        unique case (line)
            2'd0:    addr = 8'h00;
            2'd1:    addr = 8'h40;
            2'd2:    addr = 8'h14;
            default: addr = 8'h54;
        endcase
        return addr;
    endfunction

endpackage

>>> sv/lncs_chan_if.sv
// Valid/ready channel interface carrying one payload word.
interface lncs_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/lncs_front.sv
// Front end: accepts command words and classifies them for the queue.
module lncs_front (
    lncs_chan_if.sink          cmd,
    input  lncs_pkg::lncs_qstat_t qstat,
    output logic               push,
    output lncs_pkg::lncs_desc_t push_desc
);
    import lncs_pkg::*;

    logic keep;

    assign cmd.ready = !qstat.full;

    always_comb
    begin
        keep      = 1'b1;
        push_desc = '0;
        unique case (cmd.data.opcode)
            OP_INIT:
            begin
                push_desc.kind = KIND_INIT;
            end
            OP_RAW:
            begin
                push_desc.kind = KIND_SEND;
                push_desc.data = cmd.data.value;
                push_desc.rs   = cmd.data.rs_flag;
                push_desc.rw   = cmd.data.rw_flag;
                push_desc.two  = cmd.data.both_nibbles;
            end
            OP_DATA:
            begin
                push_desc.kind  = KIND_SEND;
                push_desc.data  = cmd.data.value;
                push_desc.rs    = 1'b1;
                push_desc.two   = 1'b1;
                push_desc.extra = EXTRA_DATA;
            end
            OP_CURSOR:
            begin
                if (cmd.data.value > MAX_LINE)
                begin
                    push_desc.kind = KIND_ERROR;
                end
                else
                begin
                    push_desc.kind = KIND_SEND;
                    push_desc.data = CMD_SET_DDRAM | line_addr(cmd.data.value[1:0]);
                    push_desc.two  = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                push_desc.kind  = KIND_SEND;
                push_desc.data  = CMD_CLEAR;
                push_desc.two   = 1'b1;
                push_desc.extra = EXTRA_CLEAR;
            end
            OP_HOME:
            begin
                push_desc.kind  = KIND_SEND;
                push_desc.data  = CMD_HOME;
                push_desc.two   = 1'b1;
                push_desc.extra = EXTRA_CLEAR;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = cmd.valid && cmd.ready && keep;

endmodule

>>> sv/lncs_queue.sv
// Short queue of classified commands between the front and the back.
module lncs_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lncs_pkg::lncs_desc_t  push_desc,
    input  logic                  pop,
    output lncs_pkg::lncs_qstat_t qstat,
    output lncs_pkg::lncs_desc_t  head_desc
);
    import lncs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lncs_desc_t    slots_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign head_desc        = slots_reg[rd_ptr_reg];
    assign qstat.full       = (count_reg == CW'(DEPTH));
    assign qstat.head_valid = (count_reg != '0);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full |-> !push)
        else $error("push into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !qstat.head_valid |-> !pop)
        else $error("pop from an empty queue");

endmodule

>>> sv/lncs_back.sv
// Back end: steps through the nibbles and enable phases of the head command.
module lncs_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  backlight,
    input  lncs_pkg::lncs_qstat_t qstat,
    input  lncs_pkg::lncs_desc_t  head_desc,
    output logic                  pop,
    lncs_chan_if.source           res
);
    import lncs_pkg::*;

    logic [3:0] nib_idx_reg, nib_idx_next;
    logic [1:0] phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;
    lncs_res_t  out_reg, out_next;

    logic       advance;
    logic       is_init;
    logic       final_nib;
    logic [3:0] nib;
    logic [7:0] base;
    logic [19:0] extra_us;

    assign advance = !out_valid_reg || res.ready;
    assign is_init = (head_desc.kind == KIND_INIT);

    always_comb
    begin
        if (is_init)
        begin
            nib       = init_nibble(nib_idx_reg);
            final_nib = (nib_idx_reg == INIT_LAST_NIBBLE);
            extra_us  = init_extra(nib_idx_reg);
        end
        else
        begin
            nib       = (nib_idx_reg == 4'd0) ? head_desc.data[7:4] : head_desc.data[3:0];
            final_nib = head_desc.two ? (nib_idx_reg == 4'd1) : (nib_idx_reg == 4'd0);
            unique case (head_desc.extra)
                EXTRA_DATA:  extra_us = final_nib ? EXTRA_DATA_US : 20'd0;
                EXTRA_CLEAR: extra_us = final_nib ? EXTRA_CLEAR_US : 20'd0;
                default:     extra_us = 20'd0;
            endcase
        end
        base = {nib, backlight, 1'b0, head_desc.rw && !is_init, head_desc.rs && !is_init};
    end

    always_comb
    begin
        nib_idx_next   = nib_idx_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pop            = 1'b0;
        if (advance)
        begin
            out_valid_next = qstat.head_valid;
            if (qstat.head_valid)
            begin
                if (head_desc.kind == KIND_ERROR)
                begin
                    out_next       = '0;
                    out_next.error = 1'b1;
                    out_next.last  = 1'b1;
                    pop            = 1'b1;
                end
                else
                begin
                    out_next.expander_byte  = (phase_reg == 2'd1) ? (base | ENABLE_BIT) : base;
                    out_next.wait_before_us = (is_init && nib_idx_reg == 4'd0
                                               && phase_reg == 2'd0) ? WAIT_POWER_UP_US : 16'd0;
                    out_next.wait_after_us  = STEP_US + ((phase_reg == 2'd2) ? extra_us : 20'd0);
                    out_next.error          = 1'b0;
                    out_next.last           = (phase_reg == 2'd2) && final_nib;
                    if (phase_reg == 2'd2)
                    begin
                        phase_next = 2'd0;
                        if (final_nib)
                        begin
                            nib_idx_next = 4'd0;
                            pop          = 1'b1;
                        end
                        else
                        begin
                            nib_idx_next = nib_idx_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nib_idx_reg   <= 4'd0;
            phase_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            nib_idx_reg   <= nib_idx_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.data.error) |-> (res.data.last && res.data.expander_byte == 8'h00))
        else $error("error word not a lone last word");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("enable phase out of range");

    a_nib_range: assert property (@(posedge clk) disable iff (!rst_n)
        nib_idx_reg <= INIT_LAST_NIBBLE)
        else $error("nibble index out of range");

endmodule

>>> sv/lcd_nibble_command_sequencer.sv
// Top level of the LCD nibble command sequencer: front end, queue and back end.
//
// Drives a character LCD in 4-bit mode through an I/O expander. Each word on
// the cmd channel is one LCD command; the res channel gives the expander
// bytes for it, one word per expander write, with the waits in microseconds
// to insert before and after the write, and last set on the final word of
// the command. The cfg channel writes the backlight bit; it is always ready.
//
// An accepted command is written into the queue; the back end builds its
// result words from the queue head into the registered output word: six
// words for most commands, three for a raw high nibble alone, one for a
// cursor line out of range and 45 for initialisation. Opcodes six and
// seven are dropped without a result. The back end sets the rate, one
// expander write per cycle from the queue head while the receiver is ready.
//
// When the receiver stalls, the registered result word holds and the back
// end waits; the front end keeps taking commands until the queue is full.
// Reset empties the queue, clears the output and sets the backlight bit.
module lcd_nibble_command_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input logic         clk,
    input logic         rst_n,
    lncs_chan_if.sink   cmd,
    lncs_chan_if.source res,
    lncs_chan_if.sink   cfg
);
    import lncs_pkg::*;

    // The backlight register; the user must write configuration only while
    // idle, which the block does not enforce, so the back end may read it live.
    logic backlight_reg;

    lncs_qstat_t qstat;
    lncs_desc_t  push_desc;
    lncs_desc_t  head_desc;
    logic        push;
    logic        pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backlight_reg <= 1'b1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            backlight_reg <= cfg.data;
        end
    end

    // The front end classifies each command word into a compact description.
    lncs_front u_front (
        .cmd       (cmd),
        .qstat     (qstat),
        .push      (push),
        .push_desc (push_desc)
    );

    // The queue lets the front accept while the back is still sending.
    lncs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .qstat     (qstat),
        .head_desc (head_desc)
    );

    // The back end works straight from the queue head and pops it with the
    // last word, so commands follow each other without a gap.
    lncs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .backlight (backlight_reg),
        .qstat     (qstat),
        .head_desc (head_desc),
        .pop       (pop),
        .res       (res)
    );

endmodule

>>> verif/lncs_write_checker.sv
// Checker that predicts the expander writes of each LCD command and compares them with the block.
`timescale 1ns / 1ps

module lncs_write_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  logic               cmd_ready,
    input  lncs_pkg::lncs_cmd_t cmd_word,
    input  logic               res_valid,
    input  logic               res_ready,
    input  lncs_pkg::lncs_res_t res_word,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               cfg_word,
    output int                 mismatches,
    output int                 outstanding,
    output int                 writes_checked
);
    import lncs_pkg::*;

    // Initialisation waits and commands, as the datasheet gives them.
    localparam logic [19:0] POWER_ON_SETTLE_US   = 20'd1000000;
    localparam logic [19:0] WAKE_SETTLE_US       = 20'd4500;
    localparam logic [19:0] WAKE_LAST_SETTLE_US  = 20'd150;
    localparam logic [7:0]  NIB_ZERO             = 8'h00;
    localparam logic [7:0]  NIB_WAKE             = 8'h30;
    localparam logic [7:0]  NIB_FOUR_BIT         = 8'h20;
    localparam logic [7:0]  CMD_FUNCTION_SET     = 8'h28;
    localparam logic [7:0]  CMD_DISPLAY_ON       = 8'h0F;
    localparam logic [7:0]  CMD_ENTRY_MODE       = 8'h06;
    localparam int          MAX_PRINTED          = 30;

    logic      backlight_copy;
    lncs_res_t expected_writes[$];
    lncs_res_t run_words[$];

    function automatic logic [7:0] line_start(input logic [1:0] line);
        logic [7:0] addr;
        case (line)
            2'd0:    addr = 8'h00;
            2'd1:    addr = 8'h40;
            2'd2:    addr = 8'h14;
            default: addr = 8'h54;
        endcase
        return addr;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic emit_write(input logic [7:0] pattern);
        lncs_res_t word;
        word = '0;
        word.expander_byte = pattern;
        word.wait_after_us = STEP_US;
        run_words.push_back(word);
    endtask

    // A nibble is latched by an enable pulse: low, high, low.
    task automatic strobe_nibble(input logic [7:0] pattern);
        emit_write(pattern);
        emit_write(pattern | ENABLE_BIT);
        emit_write(pattern & ~ENABLE_BIT);
    endtask

    task automatic send_byte(input logic rs, input logic rw, input logic [7:0] data,
                             input logic two);
        logic [3:0] ctl;
        ctl = {backlight_copy, 1'b0, rw, rs};
        strobe_nibble({data[7:4], ctl});
        if (two)
            strobe_nibble({data[3:0], ctl});
    endtask

    task automatic extend_final_wait(input logic [19:0] extra);
        lncs_res_t word;
        word = run_words.pop_back();
        word.wait_after_us = word.wait_after_us + extra;
        run_words.push_back(word);
    endtask

    task automatic predict_command(input lncs_cmd_t cmd);
        lncs_res_t word;
        run_words.delete();
        case (cmd.opcode)
            OP_INIT:
            begin
                send_byte(1'b0, 1'b0, NIB_ZERO, 1'b0);
                word = run_words.pop_front();
                word.wait_before_us = WAIT_POWER_UP_US;
                run_words.push_front(word);
                extend_final_wait(POWER_ON_SETTLE_US);
                send_byte(1'b0, 1'b0, NIB_WAKE, 1'b0);
                extend_final_wait(WAKE_SETTLE_US);
                send_byte(1'b0, 1'b0, NIB_WAKE, 1'b0);
                extend_final_wait(WAKE_SETTLE_US);
                send_byte(1'b0, 1'b0, NIB_WAKE, 1'b0);
                extend_final_wait(WAKE_LAST_SETTLE_US);
                send_byte(1'b0, 1'b0, NIB_FOUR_BIT, 1'b0);
                send_byte(1'b0, 1'b0, CMD_FUNCTION_SET, 1'b1);
                send_byte(1'b0, 1'b0, CMD_FUNCTION_SET, 1'b1);
                send_byte(1'b0, 1'b0, CMD_DISPLAY_ON, 1'b1);
                send_byte(1'b0, 1'b0, CMD_CLEAR, 1'b1);
                send_byte(1'b0, 1'b0, CMD_ENTRY_MODE, 1'b1);
            end
            OP_RAW:
                send_byte(cmd.rs_flag, cmd.rw_flag, cmd.value, cmd.both_nibbles);
            OP_DATA:
            begin
                send_byte(1'b1, 1'b0, cmd.value, 1'b1);
                extend_final_wait(EXTRA_DATA_US);
            end
            OP_CURSOR:
            begin
                if (cmd.value > MAX_LINE)
                begin
                    word = '0;
                    word.error = 1'b1;
                    run_words.push_back(word);
                end
                else
                    send_byte(1'b0, 1'b0, CMD_SET_DDRAM | line_start(cmd.value[1:0]), 1'b1);
            end
            OP_CLEAR:
            begin
                send_byte(1'b0, 1'b0, CMD_CLEAR, 1'b1);
                extend_final_wait(EXTRA_CLEAR_US);
            end
            OP_HOME:
            begin
                send_byte(1'b0, 1'b0, CMD_HOME, 1'b1);
                extend_final_wait(EXTRA_CLEAR_US);
            end
            default:
            begin
            end
        endcase
        if (run_words.size() > 0)
        begin
            word = run_words.pop_back();
            word.last = 1'b1;
            run_words.push_back(word);
        end
        foreach (run_words[i])
            expected_writes.push_back(run_words[i]);
    endtask

    always @(posedge clk)
    begin
        lncs_res_t want;
        if (!rst_n)
        begin
            backlight_copy = 1'b1;
            mismatches     = 0;
            writes_checked = 0;
            expected_writes.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                backlight_copy = cfg_word;
            if (cmd_valid && cmd_ready)
                predict_command(cmd_word);
            if (res_valid && res_ready)
            begin
                if (expected_writes.size() == 0)
                    report_mismatch($sformatf("write %02h arrived with nothing expected",
                                              res_word.expander_byte));
                else
                begin
                    want = expected_writes.pop_front();
                    if (res_word.expander_byte !== want.expander_byte)
                        report_mismatch($sformatf("write %0d expander_byte %02h, expected %02h",
                            writes_checked, res_word.expander_byte, want.expander_byte));
                    if (res_word.wait_before_us !== want.wait_before_us)
                        report_mismatch($sformatf("write %0d wait_before_us %0d, expected %0d",
                            writes_checked, res_word.wait_before_us, want.wait_before_us));
                    if (res_word.wait_after_us !== want.wait_after_us)
                        report_mismatch($sformatf("write %0d wait_after_us %0d, expected %0d",
                            writes_checked, res_word.wait_after_us, want.wait_after_us));
                    if (res_word.error !== want.error)
                        report_mismatch($sformatf("write %0d error %b, expected %b",
                            writes_checked, res_word.error, want.error));
                    if (res_word.last !== want.last)
                        report_mismatch($sformatf("write %0d last %b, expected %b",
                            writes_checked, res_word.last, want.last));
                    writes_checked++;
                end
            end
        end
        outstanding <= expected_writes.size();
    end

endmodule

>>> verif/lcd_nibble_command_sequencer_test.sv
// Top of the testbench: clock, reset, command and backlight stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module lcd_nibble_command_sequencer_test;
    import lncs_pkg::*;

    // The two opcodes that the block drops without any write.
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    // Cycles to let pass once nothing is expected, so that a stray write
    // after a dropped opcode would surely be seen.
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 84;
    localparam int RANDOM_PHASES  = 4;
    localparam int END_GUARD      = 20000;
    // The slowest correct run (every command an initialisation, every write
    // behind the longest stall) stays well inside this bound.
    localparam longint RUN_LIMIT_NS = 64'd10_000_000;

    logic clk = 1'b0;
    logic rst_n;

    lncs_chan_if #(.payload_t(lncs_cmd_t)) cmd_ch ();
    lncs_chan_if #(.payload_t(lncs_res_t)) res_ch ();
    lncs_chan_if #(.payload_t(logic))      cfg_ch ();

    int mismatches;
    int outstanding;
    int writes_checked;

    // Tallies of what was sent, for the closing summary.
    int issued [8];
    int cursor_errors;
    int backlight_writes [2];
    logic steady_sender;

    lcd_nibble_command_sequencer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // The checker sees every handshake on the three channels, predicts the
    // expander writes of each accepted command and compares them in order.
    lncs_write_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_ch.valid),
        .cmd_ready      (cmd_ch.ready),
        .cmd_word       (cmd_ch.data),
        .res_valid      (res_ch.valid),
        .res_ready      (res_ch.ready),
        .res_word       (res_ch.data),
        .cfg_valid      (cfg_ch.valid),
        .cfg_ready      (cfg_ch.ready),
        .cfg_word       (cfg_ch.data),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .writes_checked (writes_checked)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Most pauses are absent or short; now and then a long one, so that the
    // gaps land on every stage of a command's run of writes.
    function automatic int pause_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic lncs_cmd_t make_command(input logic [2:0] opcode, input logic [7:0] value,
                                               input logic rs, input logic rw, input logic two);
        lncs_cmd_t word;
        word.opcode       = opcode;
        word.value        = value;
        word.rs_flag      = rs;
        word.rw_flag      = rw;
        word.both_nibbles = two;
        return word;
    endfunction

    // Random command with all fields random. Raw bytes and data characters
    // dominate; initialisation is rare since it is long. Cursor commands
    // mostly name a valid line, so that the address table is well exercised.
    function automatic lncs_cmd_t random_command();
        lncs_cmd_t word;
        int pick;
        word = make_command(OP_INIT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 99);
        if (pick < 3)
            word.opcode = OP_INIT;
        else if (pick < 33)
            word.opcode = OP_RAW;
        else if (pick < 58)
            word.opcode = OP_DATA;
        else if (pick < 78)
            word.opcode = OP_CURSOR;
        else if (pick < 86)
            word.opcode = OP_CLEAR;
        else if (pick < 94)
            word.opcode = OP_HOME;
        else if (pick < 97)
            word.opcode = OP_SPARE_A;
        else
            word.opcode = OP_SPARE_B;
        if (word.opcode == OP_CURSOR && $urandom_range(0, 9) < 8)
            word.value = 8'($urandom_range(0, 3));
        return word;
    endfunction

    // Offers one command word and holds it until the block takes it. valid
    // is left high when the next word follows at once, so it is never lowered
    // and raised within one edge.
    task automatic drive_command(input lncs_cmd_t word);
        int gap;
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= word;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        issued[word.opcode]++;
        if (word.opcode == OP_CURSOR && word.value > MAX_LINE)
            cursor_errors++;
        gap = steady_sender ? 0 : pause_length();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering commands and waits until every predicted write has
    // come out, then lets a few more cycles pass for any dropped opcode.
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The backlight register is only written while the block is idle.
    task automatic write_backlight(input logic setting);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= setting;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        backlight_writes[setting]++;
        @(posedge clk);
    endtask

    // Receiver: ready in bursts of random length, broken by stalls. The odd
    // long burst gives stretches in which the block runs at full rate.
    initial
    begin
        int hold;
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            res_ch.ready <= 1'b1;
            hold = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(40, 150);
            repeat (hold) @(posedge clk);
            stall = pause_length();
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Stimulus: a directed part under both backlight settings, then random
    // phases, each with its own backlight setting, and a final drain.
    initial
    begin
        int phase_items;
        lncs_cmd_t word;

        rst_n         <= 1'b0;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.data   <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.data   <= 1'b0;
        cursor_errors = 0;
        steady_sender = 1'b0;
        foreach (issued[i])
            issued[i] = 0;
        foreach (backlight_writes[i])
            backlight_writes[i] = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First a handful of commands under the reset value of the backlight.
        drive_command(make_command(OP_DATA, 8'h41, 1'b0, 1'b0, 1'b0));
        drive_command(make_command(OP_RAW, 8'h96, 1'b1, 1'b0, 1'b1));

        write_backlight(1'b1);
        // Initialisation with the fields it ignores all set.
        drive_command(make_command(OP_INIT, 8'hFF, 1'b1, 1'b1, 1'b1));
        // Raw bytes at the extremes and with every flag combination,
        // including the high nibble alone.
        drive_command(make_command(OP_RAW, 8'h00, 1'b0, 1'b0, 1'b1));
        drive_command(make_command(OP_RAW, 8'hFF, 1'b1, 1'b1, 1'b1));
        drive_command(make_command(OP_RAW, 8'hA5, 1'b1, 1'b0, 1'b0));
        drive_command(make_command(OP_RAW, 8'h5A, 1'b0, 1'b1, 1'b0));
        drive_command(make_command(OP_DATA, 8'h00, 1'b1, 1'b1, 1'b0));
        drive_command(make_command(OP_DATA, 8'hFF, 1'b0, 1'b0, 1'b1));
        // Every valid cursor line, then lines just and far out of range.
        for (int line = 0; line <= 3; line++)
            drive_command(make_command(OP_CURSOR, 8'(line), 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        drive_command(make_command(OP_CURSOR, 8'h04, 1'b0, 1'b0, 1'b1));
        drive_command(make_command(OP_CURSOR, 8'hFF, 1'b1, 1'b1, 1'b1));
        drive_command(make_command(OP_CLEAR, 8'hFF, 1'b1, 1'b1, 1'b0));
        drive_command(make_command(OP_HOME, 8'h00, 1'b1, 1'b1, 1'b1));
        // The unused opcodes, between real commands so that a stray write
        // would be caught.
        drive_command(make_command(OP_SPARE_A, 8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b1));
        drive_command(make_command(OP_DATA, 8'h7E, 1'b0, 1'b0, 1'b0));
        drive_command(make_command(OP_SPARE_B, 8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0));

        // The same ground with the backlight off.
        write_backlight(1'b0);
        drive_command(make_command(OP_INIT, 8'h00, 1'b0, 1'b0, 1'b0));
        drive_command(make_command(OP_RAW, 8'hFF, 1'b1, 1'b1, 1'b0));
        drive_command(make_command(OP_DATA, 8'h3C, 1'b0, 1'b0, 1'b0));
        drive_command(make_command(OP_CURSOR, 8'h02, 1'b0, 1'b0, 1'b0));
        drive_command(make_command(OP_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0));
        drive_command(make_command(OP_HOME, 8'hFF, 1'b0, 1'b0, 1'b0));

        // Random phases. The first two pin the backlight to each extreme;
        // later ones pick it at random. One phase in the middle runs with no
        // sender gaps, and each phase pauses halfway for the block to drain.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                write_backlight(1'b1);
            else if (phase == 1)
                write_backlight(1'b0);
            else
                write_backlight(1'($urandom_range(0, 1)));
            steady_sender = (phase == 2);
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / RANDOM_PHASES)
            begin
                word = random_command();
                drive_command(word);
                // Dropped opcodes do nothing, so they do not count.
                if (word.opcode != OP_SPARE_A && word.opcode != OP_SPARE_B)
                begin
                    phase_items++;
                end
                if (phase_items == RANDOM_ITEMS / (2 * RANDOM_PHASES))
                    settle();
            end
        end
        steady_sender = 1'b0;

        // Drain: wait, within a bound, for every predicted write, then a few
        // more cycles so that any surplus write is seen by the checker.
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        for (int i = 0; outstanding != 0 && i < END_GUARD; i++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d commands: %0d init, %0d raw, %0d data, %0d cursor (%0d out of range),",
                 issued.sum() , issued[OP_INIT], issued[OP_RAW], issued[OP_DATA],
                 issued[OP_CURSOR], cursor_errors);
        $display("%0d clear, %0d home, %0d dropped; %0d writes checked; backlight set %0d/%0d times.",
                 issued[OP_CLEAR], issued[OP_HOME], issued[OP_SPARE_A] + issued[OP_SPARE_B],
                 writes_checked, backlight_writes[0], backlight_writes[1]);
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Guard against a block that stops handshaking.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Run timed out with %0d writes still expected.", outstanding);
        $display("== FAIL ==");
        $finish;
    end

endmodule
